@@ design/lie_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Lagrange interpolation evaluator: actions, status codes,
// sequencer states and the divider handshake type. No dependencies.
package lie_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_EVAL   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DUP = 2'd1,
        ST_SAT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP,
        S_DUP_CMP,
        S_EV_I,
        S_EV_J,
        S_EV_RD,
        S_EV_DIV,
        S_EV_MUL,
        S_EV_BAS,
        S_EV_Y,
        S_EV_ADD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_rsp;

    localparam int unsigned NUM_W  = 49;
    localparam int unsigned DEN_W  = 33;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;

endpackage

@@ design/lie_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lie_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/lie_div.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider, signed, truncating toward zero, with the
// quotient clamped to signed 32 bits. Depends on lie_pkg.
module lie_div
    import lie_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic signed [DEN_W-1:0]  i_den,
    output logic signed [31:0]       o_quo,
    output t_div_rsp                 o_rsp
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_dm;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_neg, r_done;
    logic [DEN_W:0]   w_shift;
    logic             w_big;

    // The remainder stays below the divisor, so it fits in DEN_W bits.
    always_comb begin
        w_shift = {r_rem, r_q[NUM_W-1]};
        n_q     = {r_q[NUM_W-2:0], 1'b0};
        n_rem   = w_shift[DEN_W-1:0];
        if (w_shift >= {1'b0, r_dm}) begin
            n_rem   = DEN_W'(w_shift - {1'b0, r_dm});
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_dm  <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            r_neg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    // Magnitude limits: 2^31 when negative, 2^31-1 when positive.
    always_comb begin
        if (r_neg) begin
            w_big = r_q > NUM_W'(33'h0_8000_0000);
            o_quo = w_big ? 32'sh8000_0000 : 32'(-r_q);
        end else begin
            w_big = r_q > NUM_W'(33'h0_7FFF_FFFF);
            o_quo = w_big ? 32'sh7FFF_FFFF : 32'(r_q);
        end
        o_rsp.done = r_done;
        o_rsp.ovf  = w_big;
    end

endmodule

@@ design/lagrange_interpolation_eval_top.sv @@
`timescale 1ns / 1ps
// Top level of the Lagrange interpolation evaluator: sequencer, node RAMs,
// shared multiplier and divider. Depends on lie_pkg, lie_ram and lie_div.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  input   | in        | i_valid / o_ready  | i_action, i_node_x, i_node_y, i_query_x
//  result  | out       | o_valid / i_ready  | o_value, o_status
//
// Clear and append leave the block ready; an append while full is dropped.
// An evaluation with N nodes first checks all N*(N-1)/2 pairs for a repeated
// abscissa and stops at the first repeat; if there is none, it runs
// N*(N-1) divide-multiply steps through the 49-step serial divider, with a
// basis setup and a weighted add for each node, and then finishes.
// Reset is synchronous and active low; it empties the node list and drops any
// pending result. The block takes no new transfer while an evaluation runs.
// A finished result waits in the output register until it is taken, and new
// transfers are accepted meanwhile; an evaluation that finishes before the
// previous result is taken holds in its last step, with the input stalled.
module lagrange_interpolation_eval_top
    import lie_pkg::*;
#(
    parameter int unsigned MAX_NODES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_node_x,
    input  logic signed [31:0] i_node_y,
    input  logic signed [31:0] i_query_x,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status
);

    localparam int unsigned AW = MAX_NODES > 1 ? $clog2(MAX_NODES) : 1;
    localparam int unsigned CW = $clog2(MAX_NODES + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_i, n_i, r_j, n_j;
    logic signed [31:0] r_qx, r_basis, n_basis, r_quo, n_quo;
    logic signed [63:0] r_prod, n_prod, r_acc, n_acc;
    logic              r_sat, n_sat;
    logic              r_dup, n_dup;
    logic              r_ovalid, n_ovalid;
    logic signed [31:0] r_value, n_value;
    logic [1:0]        r_status, n_status;

    logic              w_accept, w_we, w_div_start;
    logic signed [31:0] w_xa, w_xb, w_y, w_mul_b, w_quo;
    logic signed [NUM_W-1:0] w_num;
    logic signed [DEN_W-1:0] w_den, w_diff;
    logic signed [47:0] w_sh;
    logic              w_sh_fits, w_acc_fits;
    t_div_rsp          w_div;

    assign w_accept = i_valid && o_ready;
    assign w_we     = w_accept && (t_action'(i_action) == ACT_APPEND)
                      && (r_count < CW'(MAX_NODES));

    // Two copies of the abscissa store give two read ports for pair checks
    // and for reading xi and xj together.
    lie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_ram_xa (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_count[AW-1:0]), .i_wdata(i_node_x),
        .i_raddr(r_i[AW-1:0]), .o_rdata(w_xa)
    );
    lie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_ram_xb (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_count[AW-1:0]), .i_wdata(i_node_x),
        .i_raddr(r_j[AW-1:0]), .o_rdata(w_xb)
    );
    lie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_ram_y (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_count[AW-1:0]), .i_wdata(i_node_y),
        .i_raddr(r_i[AW-1:0]), .o_rdata(w_y)
    );

    // Quotient (X - xj) * 2^16 / (xi - xj).
    assign w_diff = DEN_W'(r_qx) - DEN_W'(w_xb);
    assign w_num  = {w_diff, 16'h0000};
    assign w_den  = DEN_W'(w_xa) - DEN_W'(w_xb);

    lie_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(w_den), .o_quo(w_quo), .o_rsp(w_div)
    );

    // The one multiplier serves both the basis update and the weighted term.
    assign w_mul_b    = (r_state == S_EV_Y) ? w_y : r_quo;
    assign w_sh       = r_prod[63:16];
    assign w_sh_fits  = (&w_sh[47:31]) || !(|w_sh[47:31]);
    assign w_acc_fits = (&r_acc[63:31]) || !(|r_acc[63:31]);

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_value  = r_value;
    assign o_status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_basis  <= n_basis;
        r_quo    <= n_quo;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_sat    <= n_sat;
        r_dup    <= n_dup;
        r_value  <= n_value;
        r_status <= n_status;
        if (w_accept) begin
            r_qx <= i_query_x;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_basis     = r_basis;
        n_quo       = r_quo;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_sat       = r_sat;
        n_dup       = r_dup;
        n_value     = r_value;
        n_status    = r_status;
        n_ovalid    = r_ovalid && !i_ready;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_action'(i_action))
                        ACT_CLEAR:  n_count = '0;
                        ACT_APPEND: begin
                            if (w_we) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        ACT_EVAL: begin
                            n_i     = '0;
                            n_j     = CW'(1);
                            n_acc   = '0;
                            n_sat   = 1'b0;
                            n_dup   = 1'b0;
                            n_state = S_DUP;
                        end
                        default: ;
                    endcase
                end
            end
            S_DUP: begin
                if (r_i + 1'b1 >= r_count) begin
                    n_i     = '0;
                    n_state = S_EV_I;
                end else if (r_j >= r_count) begin
                    n_i = r_i + 1'b1;
                    n_j = r_i + CW'(2);
                end else begin
                    n_state = S_DUP_CMP;
                end
            end
            S_DUP_CMP: begin
                if (w_xa == w_xb) begin
                    n_dup   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_DUP;
                end
            end
            S_EV_I: begin
                if (r_i >= r_count) begin
                    n_state = S_FIN;
                end else begin
                    n_basis = Q_ONE;
                    n_j     = '0;
                    n_state = S_EV_J;
                end
            end
            S_EV_J: begin
                if (r_j >= r_count) begin
                    n_state = S_EV_Y;
                end else if (r_j == r_i) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = S_EV_RD;
                end
            end
            S_EV_RD: begin
                w_div_start = 1'b1;
                n_state     = S_EV_DIV;
            end
            S_EV_DIV: begin
                if (w_div.done) begin
                    n_quo   = w_quo;
                    n_sat   = r_sat || w_div.ovf;
                    n_state = S_EV_MUL;
                end
            end
            S_EV_MUL: begin
                n_prod  = r_basis * w_mul_b;
                n_state = S_EV_BAS;
            end
            S_EV_BAS: begin
                if (w_sh_fits) begin
                    n_basis = w_sh[31:0];
                end else begin
                    n_basis = w_sh[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    n_sat   = 1'b1;
                end
                n_j     = r_j + 1'b1;
                n_state = S_EV_J;
            end
            S_EV_Y: begin
                n_prod  = r_basis * w_mul_b;
                n_state = S_EV_ADD;
            end
            S_EV_ADD: begin
                n_acc   = r_acc + 64'(w_sh);
                n_i     = r_i + 1'b1;
                n_state = S_EV_I;
            end
            S_FIN: begin
                // The output register is loaded only once the previous
                // result has left it.
                if (!r_ovalid || i_ready) begin
                    if (r_dup) begin
                        n_value  = '0;
                        n_status = ST_DUP;
                    end else if (w_acc_fits) begin
                        n_value  = r_acc[31:0];
                        n_status = r_sat ? ST_SAT : ST_OK;
                    end else begin
                        n_value  = r_acc[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        n_status = ST_SAT;
                    end
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ design/lie_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the Lagrange interpolation evaluator, bound to the
// top level. Depends on lie_pkg and lagrange_interpolation_eval_top.
module lie_checker
    import lie_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_action,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_value,
    input logic [1:0]  o_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_action == ACT_EVAL |=> !o_ready)
        else $error("ready during evaluation");

    a_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DUP |-> o_value == 32'h0)
        else $error("duplicate status with nonzero value");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("undefined status code");

endmodule

bind lagrange_interpolation_eval_top lie_checker u_lie_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_action(i_action), .o_valid(o_valid), .i_ready(i_ready),
    .o_value(o_value), .o_status(o_status)
);

@@ bench/lagrange_interpolation_eval_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the Lagrange interpolation evaluator: directed table, then
// random node sets and evaluations under several idling phases, checked
// against a Q16.16 predictor. Depends on lie_pkg and the design top level.
module lagrange_interpolation_eval_top_tb;
    import lie_pkg::*;

    localparam int unsigned MAX_NODES = 16;
    localparam longint      LIMIT     = 10_000_000;

    // One row of the directed table. When chk is set the typed-in result is
    // compared against the predictor's answer as an extra sanity check.
    typedef struct {
        t_action     act;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] qx;
        bit          chk;
        logic [31:0] val;
        t_status     st;
    } t_row;

    typedef struct {
        logic [31:0] value;
        t_status     status;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_action;
    logic signed [31:0] i_node_x;
    logic signed [31:0] i_node_y;
    logic signed [31:0] i_query_x;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_value;
    logic [1:0]         o_status;

    lagrange_interpolation_eval_top #(.MAX_NODES(MAX_NODES)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .i_node_x (i_node_x),
        .i_node_y (i_node_y),
        .i_query_x(i_query_x),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_value  (o_value),
        .o_status (o_status)
    );

    // Predictor state: a private copy of the node list.
    logic [31:0] pred_x [MAX_NODES];
    logic [31:0] pred_y [MAX_NODES];
    int unsigned pred_count;

    // Results still owed by the block, oldest first.
    t_result     pending_results[$];
    int unsigned mismatches;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_off;
    longint      cycles = 0;

    // Clock: 10 ns period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint clamp32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Floor division by 2^16; an arithmetic shift floors on two's complement.
    function automatic longint floor_q16(input longint v);
        return v >>> 16;
    endfunction

    // Lagrange evaluation in Q16.16 with the block's rounding and clamping.
    function automatic t_result lagrange_eval(input logic [31:0] qx_bits);
        t_result r;
        longint  qx, xi, xj, basis, quo, sum;
        bit      sat;
        sat = 1'b0;
        for (int i = 0; i < pred_count; i++) begin
            for (int j = i + 1; j < pred_count; j++) begin
                if (pred_x[i] == pred_x[j]) begin
                    r.value  = '0;
                    r.status = ST_DUP;
                    return r;
                end
            end
        end
        qx  = longint'($signed(qx_bits));
        sum = 0;
        for (int i = 0; i < pred_count; i++) begin
            xi    = longint'($signed(pred_x[i]));
            basis = 65536;
            for (int j = 0; j < pred_count; j++) begin
                if (j != i) begin
                    xj    = longint'($signed(pred_x[j]));
                    // SystemVerilog division truncates toward zero, as needed.
                    quo   = clamp32(((qx - xj) * 65536) / (xi - xj), sat);
                    basis = clamp32(floor_q16(basis * quo), sat);
                end
            end
            sum += floor_q16(basis * longint'($signed(pred_y[i])));
        end
        sum      = clamp32(sum, sat);
        r.value  = sum[31:0];
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    // Applies one accepted transfer to the predictor.
    task automatic predict_item(input t_action act, input logic [31:0] nx,
                                input logic [31:0] ny, input logic [31:0] qx);
        case (act)
            ACT_CLEAR: begin
                pred_count = 0;
            end
            ACT_APPEND: begin
                if (pred_count < MAX_NODES) begin
                    pred_x[pred_count] = nx;
                    pred_y[pred_count] = ny;
                    pred_count++;
                end
            end
            ACT_EVAL: begin
                pending_results.insert(pending_results.size(), lagrange_eval(qx));
            end
            default: begin
            end
        endcase
    endtask

    // Offers one transfer, with random idling before it, and waits for it.
    // Valid stays high between back-to-back transfers.
    task automatic send_item(input t_action act, input logic [31:0] nx,
                             input logic [31:0] ny, input logic [31:0] qx);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_node_x  <= nx;
        i_node_y  <= ny;
        i_query_x <= qx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_item(act, nx, ny, qx);
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random Q16.16 abscissa, mostly small so that bases stay in range.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return $urandom();
            1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(16)) - 8) <<< 16
                            | 32'($urandom_range(1) ? 32'h8000 : 0);
        endcase
    endfunction

    // Result side: random stall, long hold-off on request, and the check.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result value=%h status=%0d", o_value, o_status);
                end else begin
                    if (o_value !== pending_results[0].value ||
                        o_status !== pending_results[0].status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value=%h status=%0d, got %h %0d",
                                     pending_results[0].value,
                                     pending_results[0].status, o_value, o_status);
                    end
                    void'(pending_results.pop_front());
                end
            end
            i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The receiver's long hold-off, counted in cycles of its own.
    task automatic receiver_hold(input int unsigned n);
        hold_off = 1'b1;
        repeat (n) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_row table_rows[$];
        t_result r;
        int unsigned n;

        mismatches     = 0;
        pred_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = ACT_CLEAR;
        i_node_x       = '0;
        i_node_y       = '0;
        i_query_x      = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty list, single node, extremes, duplicates,
        // saturation, unused action.
        table_rows = '{
            '{ACT_EVAL,   32'h0, 32'h0, 32'h7FFF_FFFF, 1, 32'h0, ST_OK},
            '{ACT_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, ST_OK},
            '{ACT_EVAL,   32'h0, 32'h0, 32'h8000_0000, 1, 32'h0, ST_OK},
            '{ACT_APPEND, 32'h0001_0000, 32'h0003_0000, 32'h0, 0, 0, ST_OK},
            '{ACT_EVAL,   32'h0, 32'h0, 32'h1234_5678, 1, 32'h0003_0000, ST_OK},
            '{ACT_APPEND, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 0, 0, ST_OK},
            '{ACT_EVAL,   32'h0, 32'h0, 32'h0, 1, 32'h0, ST_DUP},
            '{ACT_CLEAR,  32'h0, 32'h0, 32'h0, 0, 0, ST_OK},
            '{ACT_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 0, 0, ST_OK},
            '{ACT_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h0, 0, 0, ST_OK},
            '{ACT_EVAL,   32'h0, 32'h0, 32'h7FFF_FFFF, 0, 0, ST_OK},
            '{ACT_EVAL,   32'h0, 32'h0, 32'h8000_0000, 0, 0, ST_OK},
            '{ACT_CLEAR,  32'h0, 32'h0, 32'h0, 0, 0, ST_OK},
            '{ACT_APPEND, 32'h0, 32'h7FFF_FFFF, 32'h0, 0, 0, ST_OK},
            '{ACT_APPEND, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0, 0, 0, ST_OK},
            '{ACT_EVAL,   32'h0, 32'h0, 32'h7FFF_0000, 0, 0, ST_OK},
            '{ACT_CLEAR,  32'h0, 32'h0, 32'h0, 0, 0, ST_OK},
            '{ACT_EVAL,   32'h0, 32'h0, 32'h0001_0000, 1, 32'h0, ST_OK}
        };
        foreach (table_rows[k]) begin
            if (table_rows[k].chk && table_rows[k].act == ACT_EVAL) begin
                r = lagrange_eval(table_rows[k].qx);
                if (r.value !== table_rows[k].val || r.status !== table_rows[k].st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: expected %h %0d, predicted %h %0d",
                                 k, table_rows[k].val, table_rows[k].st, r.value, r.status);
                end
            end
            send_item(table_rows[k].act, table_rows[k].nx, table_rows[k].ny,
                      table_rows[k].qx);
        end

        // Fill past capacity so the append-when-full path is exercised.
        for (int k = 0; k < MAX_NODES + 2; k++)
            send_item(ACT_APPEND, 32'(k) <<< 14, $urandom(), 0);
        send_item(ACT_EVAL, 0, 0, 32'h0000_8000);
        wait_drained();

        // Random part: mostly fresh small node sets then a few evaluations.
        // Phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 83 : 35) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 83 : 35) : 0;
            for (int s = 0; s < 3; s++) begin
                send_item(ACT_CLEAR, $urandom(), $urandom(), $urandom());
                n = ($urandom_range(7) == 0) ? $urandom_range(MAX_NODES) : $urandom_range(4);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(15) == 0)
                        send_item(t_action'($urandom_range(3)), $urandom(), $urandom(),
                                  $urandom());
                    else
                        send_item(ACT_APPEND, rand_coord(), $urandom(), $urandom());
                end
                repeat ($urandom_range(1, 3))
                    send_item(ACT_EVAL, $urandom(), $urandom(), rand_coord());
            end
            // Pause the sender until every result has come back.
            wait_drained();
        end

        // Long receiver hold-off while evaluations keep being offered.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(ACT_CLEAR, 0, 0, 0);
        send_item(ACT_APPEND, 32'h0001_0000, 32'h0002_0000, 0);
        send_item(ACT_APPEND, 32'h0002_0000, 32'h0005_0000, 0);
        fork
            receiver_hold(3000);
            for (int k = 0; k < 4; k++)
                send_item(ACT_EVAL, 0, 0, rand_coord());
        join

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ lagrange_interpolation_eval_top.f @@
design/lie_pkg.sv
design/lie_ram.sv
design/lie_div.sv
design/lagrange_interpolation_eval_top.sv
design/lie_checker.sv
bench/lagrange_interpolation_eval_top_tb.sv
